>>> hdl/hftc_pkg.sv
package hftc_pkg;

    localparam int RAW_W   = 16;
    localparam int CRC_W   = 8;
    localparam int SCALE_W = 15;
    localparam int PROD_W  = RAW_W + SCALE_W;
    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [CRC_W-1:0]   CRC_POLY   = 8'h31;
    localparam logic [CRC_W-1:0]   CRC_INIT   = 8'hFF;
    localparam logic [SCALE_W-1:0] TEMP_SCALE = 15'd17500;
    localparam logic [SCALE_W-1:0] HUM_SCALE  = 15'd10000;
    localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 15'd4500;

    // One lane's finding for one word
    typedef struct packed {
        logic              crc_ok;
        logic [CRC_W-1:0]  crc;
        logic [PROD_W-1:0] prod;
    } lane_res_t;

    // CRC-8, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/hftc_lane.sv
module hftc_lane (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [hftc_pkg::RAW_W-1:0]    word,
    input  logic [hftc_pkg::CRC_W-1:0]    check,
    input  logic [hftc_pkg::SCALE_W-1:0]  scale,
    output hftc_pkg::lane_res_t           res
);
    import hftc_pkg::*;

    logic [CRC_W-1:0] crc_hi;
    logic [CRC_W-1:0] crc_full;
    lane_res_t        res_reg;
    lane_res_t        res_next;

    // CRC over high byte then low byte; scale the raw word
    always_comb begin
        crc_hi          = crc8_byte(CRC_INIT, word[RAW_W-1:8]);
        crc_full        = crc8_byte(crc_hi, word[7:0]);
        res_next.crc    = crc_full;
        res_next.crc_ok = (crc_full == check);
        res_next.prod   = PROD_W'(word) * PROD_W'(scale);
    end

    // Hold the lane result until the next word moves in
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> hdl/hftc_merge.sv
module hftc_merge (
    input  logic                          aclk,
    input  logic                          load,
    input  hftc_pkg::lane_res_t           temp_res,
    input  hftc_pkg::lane_res_t           hum_res,
    output logic                          status,
    output logic [hftc_pkg::TEMP_W-1:0]   temperature_centi,
    output logic [hftc_pkg::HUM_W-1:0]    humidity_centi,
    output logic [hftc_pkg::CRC_W-1:0]    calc_temp_crc,
    output logic [hftc_pkg::CRC_W-1:0]    calc_hum_crc
);
    import hftc_pkg::*;

    logic [PROD_W:0]     temp_sum;
    logic [PROD_W:0]     hum_sum;
    logic [TEMP_W-1:0]   temp_quot;
    logic [HUM_W-1:0]    hum_quot;
    logic                ok;
    logic                status_reg, status_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic [HUM_W-1:0]    hum_reg, hum_next;
    logic [CRC_W-1:0]    tcrc_reg, hcrc_reg;

    // Divide by 65535: q = (p + (p >> 16) + 1) >> 16, exact while q < 65536
    always_comb begin
        temp_sum  = (PROD_W+1)'(temp_res.prod) + (PROD_W+1)'(temp_res.prod[PROD_W-1:16])
                    + (PROD_W+1)'(1);
        hum_sum   = (PROD_W+1)'(hum_res.prod) + (PROD_W+1)'(hum_res.prod[PROD_W-1:16])
                    + (PROD_W+1)'(1);
        temp_quot = temp_sum[16 +: TEMP_W];
        hum_quot  = hum_sum[16 +: HUM_W];
        ok        = temp_res.crc_ok && hum_res.crc_ok;
        status_next = !ok;
        temp_next = ok ? (temp_quot - TEMP_OFFSET) : '0;
        hum_next  = ok ? hum_quot : '0;
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            tcrc_reg   <= temp_res.crc;
            hcrc_reg   <= hum_res.crc;
        end
    end

    assign status            = status_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;
    assign calc_temp_crc     = tcrc_reg;
    assign calc_hum_crc      = hcrc_reg;

endmodule

>>> hdl/humidity_temp_frame_check.sv
// An input word is registered in the lanes, then in the merge stage, before m_*.
// One word per cycle when not stalled; two lanes (temperature, humidity) each run
// an unrolled CRC-8 and a 16x15 multiply, then one merge stage divides by 65535.
// A stalled output holds one word in each stage; input stops once both are full.
// Reset: aresetn (synchronous, active low) empties both stages; no other state.
module humidity_temp_frame_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] raw_temp, [23:16] temp_check, [39:24] raw_hum, [47:40] hum_check
    input  logic [hftc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi,
    // [36:29] calc_temp_crc, [44:37] calc_hum_crc, [47:45] zero
    output logic [hftc_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] status
    output logic                               m_tuser
);
    import hftc_pkg::*;

    logic            lane_valid_reg, lane_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    logic            lane_load;
    logic            out_load;
    lane_res_t       temp_res;
    lane_res_t       hum_res;
    logic            status;
    logic [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]  humidity_centi;
    logic [CRC_W-1:0]  calc_temp_crc;
    logic [CRC_W-1:0]  calc_hum_crc;

    // Load a stage when it is empty or the one after it is free
    always_comb begin
        out_free        = !out_valid_reg || m_tready;
        out_load        = lane_valid_reg && out_free;
        s_tready        = !lane_valid_reg || out_free;
        lane_load       = s_tvalid && s_tready;
        lane_valid_next = lane_load ? 1'b1 : (out_load ? 1'b0 : lane_valid_reg);
        out_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    hftc_lane u_temp_lane (
        .aclk  (aclk),
        .load  (lane_load),
        .word  (s_tdata[15:0]),
        .check (s_tdata[23:16]),
        .scale (TEMP_SCALE),
        .res   (temp_res)
    );

    hftc_lane u_hum_lane (
        .aclk  (aclk),
        .load  (lane_load),
        .word  (s_tdata[39:24]),
        .check (s_tdata[47:40]),
        .scale (HUM_SCALE),
        .res   (hum_res)
    );

    hftc_merge u_merge (
        .aclk              (aclk),
        .load              (out_load),
        .temp_res          (temp_res),
        .hum_res           (hum_res),
        .status            (status),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .calc_temp_crc     (calc_temp_crc),
        .calc_hum_crc      (calc_hum_crc)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status;
    assign m_tdata  = {3'b000, calc_hum_crc, calc_temp_crc, humidity_centi, temperature_centi};

    // A word waiting in the lane stage behind a stalled output stays put
    a_lane_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid_reg && out_valid_reg && !m_tready) |=> lane_valid_reg)
        else $error("lane word lost during output stall");

    // A mismatch result carries zero scaled values
    a_zero_on_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[28:0] == 29'd0))
        else $error("scaled values nonzero on CRC mismatch");

    // Humidity never exceeds 100.00 percent
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
        else $error("humidity out of range");

    // Input is refused only when both stages are full and the output stalls
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (lane_valid_reg && out_valid_reg && !m_tready))
        else $error("input refused with room available");

endmodule
